/* hdl/windowed_sample_statistics_macros.svh */
`ifndef WINDOWED_SAMPLE_STATISTICS_MACROS_SVH
`define WINDOWED_SAMPLE_STATISTICS_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define WSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define WSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/wss_pkg.sv */
package wss_pkg;

  localparam int unsigned MaxWindowLog2 = 16;

  // Configuration port
  localparam int unsigned CfgW     = 5;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;
  localparam logic        RegWindowLog2 = 1'b0;
  localparam logic [CfgW-1:0] WindowLog2Reset = 5'd10;

  // Window extreme reset values
  localparam logic signed [31:0] LowReset  = 32'sh7fff_ffff;
  localparam logic signed [31:0] HighReset = 32'sh8000_0001;

  // Request queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QFillW = $clog2(QDepth + 1);

  // Iterative divider
  localparam int unsigned DivNumW = 64;
  localparam int unsigned DivCntW = $clog2(DivNumW + 1);

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_COMPUTE,
    CMD_CLEAR,
    CMD_NONE
  } cmd_e;

  typedef enum logic [1:0] {
    MUL_SAMPLE,
    MUL_SUM_LO,
    MUL_CROSS,
    MUL_COUNT
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_MS,
    DIV_MEAN,
    DIV_VAR
  } div_step_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_SQ_LO,
    ST_SQ_CROSS,
    ST_SQ_SUM,
    ST_PUB_FULL,
    ST_PUB_PART,
    ST_PUB_EMPTY,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] sample;
  } wss_in_t;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic signed [63:0] mean_value;
    logic signed [63:0] mean_square;
    logic signed [63:0] variance_value;
    logic signed [31:0] overall_min;
    logic signed [31:0] overall_max;
    logic               window_done;
  } wss_out_t;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] sample;
  } wss_cmd_t;

endpackage

/* hdl/wss_front.sv */
module wss_front
  import wss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  wss_in_t  in_data_i,
  output logic     q_valid_o,
  output wss_cmd_t q_entry_o,
  input  logic     q_pop_i
);

  wss_cmd_t              fifo_q [QDepth];
  logic [QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QFillW-1:0]     fill_q;
  wss_cmd_t              entry;
  logic                  push;
  logic                  pop;

  // Classify the request; the unused code becomes CMD_NONE, which leaves the statistics unchanged.
  always_comb begin
    entry.sample = in_data_i.sample;
    case (in_data_i.operation)
      OP_ADD:     entry.cmd = CMD_ADD;
      OP_COMPUTE: entry.cmd = CMD_COMPUTE;
      OP_CLEAR:   entry.cmd = CMD_CLEAR;
      default:    entry.cmd = CMD_NONE;
    endcase
  end

  assign in_ready_o = (fill_q != QFillW'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (fill_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_entry_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

/* hdl/wss_div.sv */
module wss_div
  import wss_pkg::*;
#(
  parameter int unsigned DEN_W = 2 * (MaxWindowLog2 + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] dividend_i,
  input  logic [DEN_W-1:0]   divisor_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quotient_o
);

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivNumW-1:0] quo_q;
  logic [DEN_W-1:0]   rem_q, den_q;
  logic [DEN_W:0]     rem_sh, rem_nx;
  logic               ge;

  // Restoring division: one quotient bit per cycle, MSB first.
  assign rem_sh = {rem_q, quo_q[DivNumW-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DivCntW'(DivNumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivNumW-2:0], ge};
      rem_q <= rem_nx[DEN_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hdl/wss_back.sv */
`include "windowed_sample_statistics_macros.svh"

module wss_back
  import wss_pkg::*;
#(
  parameter int unsigned MAX_WINDOW_LOG2 = MaxWindowLog2,
  localparam int unsigned CntW = MAX_WINDOW_LOG2 + 1,
  localparam int unsigned KW   = $clog2(MAX_WINDOW_LOG2 + 1),
  localparam int unsigned DenW = 2 * CntW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [KW-1:0] k_i,
  input  logic          q_valid_i,
  input  wss_cmd_t      q_entry_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output wss_out_t      out_data_o
);

  typedef struct packed {
    logic     pop;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc;
    logic     sq_take;
    logic     sq_add;
    logic     pub_full;
    logic     pub_part;
    logic     pub_empty;
    logic     clear;
    logic     done_now;
    logic     div_start;
    logic     div_take;
    logic     emit;
  } ctrl_t;

  back_state_e state_q, state_d;
  ctrl_t       ctl;

  // Window and all-time state
  logic [CntW-1:0]    count_q, count_d;
  logic [63:0]        sum_q, sum_d, sumsq_q, sumsq_d;
  logic signed [31:0] low_q, low_d, high_q, high_d;
  logic signed [31:0] ever_low_q, ever_low_d, ever_high_q, ever_high_d;

  // Published values
  logic signed [31:0] pub_min_q, pub_min_d, pub_max_q, pub_max_d;
  logic [63:0]        pub_mean_q, pub_mean_d, pub_ms_q, pub_ms_d, pub_var_q, pub_var_d;

  // Working registers
  logic signed [31:0] sample_q;
  logic [63:0]        prod_q, sq_q, sq_d, ms_q, ms_d, mean_q, mean_d;
  logic               partial_q, done_q, done_d;
  div_step_e          div_step_q, div_step_d;
  logic               out_valid_q;
  wss_out_t           out_q, out_next;

  logic               out_free;
  logic [CntW-1:0]    count_inc;
  logic               full;
  logic [63:0]        sample_ext, ms_sh, mean_sh, sq_sh;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [63:0]        div_num, div_quot, sum_mag, sq_mag;
  logic [DenW-1:0]    div_den;
  logic               div_done;

  assign out_free   = !out_valid_q || out_ready_i;
  assign count_inc  = count_q + 1'b1;
  assign full       = (count_inc >= (CntW'(1) << k_i));
  assign sample_ext = {{32{sample_q[31]}}, sample_q};
  assign ms_sh      = $signed(sumsq_q) >>> k_i;
  assign mean_sh    = $signed(sum_q) >>> k_i;
  assign sq_sh      = $signed(sq_q) >>> {k_i, 1'b0};
  assign sum_mag    = sum_q[63] ? (64'd0 - sum_q) : sum_q;
  assign sq_mag     = sq_q[63] ? (64'd0 - sq_q) : sq_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_entry_i.cmd)
            CMD_ADD:     state_d = ST_ACC;
            CMD_COMPUTE: state_d = (count_q == '0) ? ST_PUB_EMPTY : ST_SQ_LO;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACC: begin
        if (full) begin
          state_d = ST_SQ_LO;
        end else begin
          state_d = out_free ? ST_IDLE : ST_EMIT;
        end
      end
      ST_SQ_LO:    state_d = ST_SQ_CROSS;
      ST_SQ_CROSS: state_d = ST_SQ_SUM;
      ST_SQ_SUM:   state_d = partial_q ? ST_DIV_GO : ST_PUB_FULL;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (div_step_q == DIV_VAR) ? ST_PUB_PART : ST_DIV_GO;
        end
      end
      ST_PUB_FULL, ST_PUB_PART, ST_PUB_EMPTY, ST_EMIT: begin
        state_d = out_free ? ST_IDLE : ST_EMIT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    ctl         = '0;
    ctl.mul_sel = MUL_SAMPLE;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_entry_i.cmd)
            CMD_ADD: begin
              ctl.pop    = 1'b1;
              ctl.mul_en = 1'b1;
            end
            CMD_COMPUTE: ctl.pop = 1'b1;
            CMD_CLEAR: begin
              ctl.pop   = out_free;
              ctl.clear = out_free;
              ctl.emit  = out_free;
            end
            default: begin
              ctl.pop  = out_free;
              ctl.emit = out_free;
            end
          endcase
        end
      end
      ST_ACC: begin
        ctl.acc  = 1'b1;
        ctl.emit = !full && out_free;
      end
      ST_SQ_LO: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_SUM_LO;
      end
      ST_SQ_CROSS: begin
        ctl.sq_take = 1'b1;
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_CROSS;
      end
      ST_SQ_SUM: begin
        ctl.sq_add  = 1'b1;
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_COUNT;
      end
      ST_PUB_FULL: begin
        ctl.pub_full = 1'b1;
        ctl.clear    = 1'b1;
        ctl.done_now = 1'b1;
        ctl.emit     = out_free;
      end
      ST_PUB_PART: begin
        ctl.pub_part = 1'b1;
        ctl.emit     = out_free;
      end
      ST_PUB_EMPTY: begin
        ctl.pub_empty = 1'b1;
        ctl.emit      = out_free;
      end
      ST_DIV_GO:   ctl.div_start = 1'b1;
      ST_DIV_WAIT: ctl.div_take  = div_done;
      ST_EMIT:     ctl.emit      = out_free;
      default:     ctl           = '0;
    endcase
  end

  assign q_pop_o = ctl.pop;

  // Shared 33x33 multiplier; product registered before use.
  always_comb begin
    case (ctl.mul_sel)
      MUL_SAMPLE: begin
        mul_a = {q_entry_i.sample[31], q_entry_i.sample};
        mul_b = mul_a;
      end
      MUL_SUM_LO: begin
        mul_a = {1'b0, sum_q[31:0]};
        mul_b = mul_a;
      end
      MUL_CROSS: begin
        mul_a = {1'b0, sum_q[63:32]};
        mul_b = {1'b0, sum_q[31:0]};
      end
      MUL_COUNT: begin
        mul_a = {{(33 - CntW){1'b0}}, count_q};
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Divider operands by step
  always_comb begin
    case (div_step_q)
      DIV_MEAN: begin
        div_num = sum_mag;
        div_den = DenW'(count_q);
      end
      DIV_VAR: begin
        div_num = sq_mag;
        div_den = prod_q[DenW-1:0];
      end
      default: begin
        div_num = sumsq_q;
        div_den = DenW'(count_q);
      end
    endcase
  end

  wss_div #(
    .DEN_W(DenW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (ctl.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Datapath next values
  always_comb begin
    count_d     = count_q;
    sum_d       = sum_q;
    sumsq_d     = sumsq_q;
    low_d       = low_q;
    high_d      = high_q;
    ever_low_d  = ever_low_q;
    ever_high_d = ever_high_q;
    pub_min_d   = pub_min_q;
    pub_max_d   = pub_max_q;
    pub_mean_d  = pub_mean_q;
    pub_ms_d    = pub_ms_q;
    pub_var_d   = pub_var_q;
    sq_d        = sq_q;
    ms_d        = ms_q;
    mean_d      = mean_q;
    div_step_d  = div_step_q;

    if (ctl.acc) begin
      count_d = count_inc;
      sum_d   = sum_q + sample_ext;
      sumsq_d = sumsq_q + prod_q;
      if (sample_q < low_q) begin
        low_d = sample_q;
        if (sample_q < ever_low_q) begin
          ever_low_d = sample_q;
        end
      end
      if (sample_q > high_q) begin
        high_d = sample_q;
        if (sample_q > ever_high_q) begin
          ever_high_d = sample_q;
        end
      end
    end

    if (ctl.sq_take) begin
      sq_d = prod_q;
    end
    if (ctl.sq_add) begin
      sq_d = sq_q + {prod_q[30:0], 33'd0};
    end

    if (ctl.pop) begin
      div_step_d = DIV_MS;
    end else if (ctl.div_take) begin
      case (div_step_q)
        DIV_MS: begin
          ms_d       = div_quot;
          div_step_d = DIV_MEAN;
        end
        DIV_MEAN: begin
          mean_d     = sum_q[63] ? (64'd0 - div_quot) : div_quot;
          div_step_d = DIV_VAR;
        end
        default: begin
          sq_d       = sq_q[63] ? (64'd0 - div_quot) : div_quot;
          div_step_d = DIV_MS;
        end
      endcase
    end

    if (ctl.pub_full) begin
      pub_min_d  = low_q;
      pub_max_d  = high_q;
      pub_mean_d = mean_sh;
      pub_ms_d   = ms_sh;
      pub_var_d  = ms_sh - sq_sh;
    end
    if (ctl.pub_part) begin
      pub_min_d  = low_q;
      pub_max_d  = high_q;
      pub_mean_d = mean_q;
      pub_ms_d   = ms_q;
      pub_var_d  = ms_q - sq_q;
    end
    if (ctl.pub_empty) begin
      pub_min_d  = low_q;
      pub_max_d  = high_q;
      pub_mean_d = '0;
      pub_ms_d   = '0;
      pub_var_d  = '0;
    end

    if (ctl.clear) begin
      count_d = '0;
      sum_d   = '0;
      sumsq_d = '0;
      low_d   = LowReset;
      high_d  = HighReset;
    end

    done_d = (state_q == ST_EMIT) ? done_q : ctl.done_now;
  end

  always_comb begin
    out_next.min_value      = pub_min_d;
    out_next.max_value      = pub_max_d;
    out_next.mean_value     = pub_mean_d;
    out_next.mean_square    = pub_ms_d;
    out_next.variance_value = pub_var_d;
    out_next.overall_min    = ever_low_d;
    out_next.overall_max    = ever_high_d;
    out_next.window_done    = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      partial_q   <= 1'b0;
      done_q      <= 1'b0;
      div_step_q  <= DIV_MS;
      count_q     <= '0;
      sum_q       <= '0;
      sumsq_q     <= '0;
      low_q       <= LowReset;
      high_q      <= HighReset;
      ever_low_q  <= LowReset;
      ever_high_q <= HighReset;
      pub_min_q   <= '0;
      pub_max_q   <= '0;
      pub_mean_q  <= '0;
      pub_ms_q    <= '0;
      pub_var_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= ctl.emit || (out_valid_q && !out_ready_i);
      if (ctl.pop) begin
        partial_q <= (q_entry_i.cmd == CMD_COMPUTE);
      end
      done_q      <= done_d;
      div_step_q  <= div_step_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      sumsq_q     <= sumsq_d;
      low_q       <= low_d;
      high_q      <= high_d;
      ever_low_q  <= ever_low_d;
      ever_high_q <= ever_high_d;
      pub_min_q   <= pub_min_d;
      pub_max_q   <= pub_max_d;
      pub_mean_q  <= pub_mean_d;
      pub_ms_q    <= pub_ms_d;
      pub_var_q   <= pub_var_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.pop) begin
      sample_q <= q_entry_i.sample;
    end
    if (ctl.mul_en) begin
      prod_q <= mul_p[63:0];
    end
    sq_q   <= sq_d;
    ms_q   <= ms_d;
    mean_q <= mean_d;
    if (ctl.emit) begin
      out_q <= out_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `WSS_ASSERT_IMP(a_emit_free, clk_i, rst_ni, ctl.emit, !out_valid_q || out_ready_i, "result overwrites a pending one")
  `WSS_ASSERT_IMP(a_div_expected, clk_i, rst_ni, div_done, state_q == ST_DIV_WAIT, "divider result arrives unexpected")
  `WSS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, state_q == ST_IDLE, !count_q[CntW-1], "window count passes its maximum")
  `WSS_ASSERT_NXT(a_add_accumulates, clk_i, rst_ni, ctl.pop && (q_entry_i.cmd == CMD_ADD), state_q == ST_ACC, "add request skips accumulation")

endmodule

/* hdl/windowed_sample_statistics.sv */
// Channel | Dir | Handshake                          | Payload
// in      | in  | in_valid_i / in_ready_o            | in_data_i  (wss_in_t: operation, sample)
// out     | out | out_valid_o / out_ready_i          | out_data_o (wss_out_t: published stats)
// cfg     | in  | APB psel/penable/pwrite, pready=1  | paddr, pwdata, prdata (window_log2)
//
// An add pops and squares the sample in the back end, then accumulates and
// loads the result; one that closes a window goes on to three multiplier passes
// (low-half square, cross term, count square), then the shift-based publish.
// A compute on a non-empty window runs three 64-bit divisions on the shared
// restoring divider, plus squaring and publish; on an empty window it publishes
// zeros. Clear and the unused operation code are handled in the idle state.
// Reset loads window_log2 = 10, clears the window, the all-time extremes and
// the published values; no clearing pass is needed.
// A 2-entry request queue lets the front keep accepting while the back works;
// a full output register stalls the back in place without losing state.

module windowed_sample_statistics
  import wss_pkg::*;
#(
  parameter int unsigned MAX_WINDOW_LOG2 = MaxWindowLog2
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wss_in_t           in_data_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wss_out_t          out_data_o,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned KW = $clog2(MAX_WINDOW_LOG2 + 1);

  logic [CfgW-1:0] cfg_q;
  logic [KW-1:0]   k;
  logic            cfg_hit;
  logic            q_valid;
  wss_cmd_t        q_entry;
  logic            q_pop;

  // Register file: one word, window_log2, at byte address 0. The word index
  // is the top address bit; the byte offset bits are ignored.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[PaddrW-1] == RegWindowLog2);
  assign prdata  = cfg_hit ? PdataW'(cfg_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= WindowLog2Reset;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      cfg_q <= pwdata[CfgW-1:0];
    end
  end

  // Clamp the window size: anything above the maximum acts as the maximum.
  assign k = (cfg_q > CfgW'(MAX_WINDOW_LOG2)) ? KW'(MAX_WINDOW_LOG2) : KW'(cfg_q);

  // Front: accept and classify requests into the queue.
  wss_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .q_valid_o (q_valid),
    .q_entry_o (q_entry),
    .q_pop_i   (q_pop)
  );

  // Back: accumulate, publish and drive the output register.
  wss_back #(
    .MAX_WINDOW_LOG2(MAX_WINDOW_LOG2)
  ) u_back (
    .clk_i,
    .rst_ni,
    .k_i       (k),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule
